/* sv/rle_lit_pkg.sv */
package rle_lit_pkg;

  // Run token limits and header flag
  localparam logic [6:0] RUN_MIN  = 7'd4;
  localparam logic [6:0] RUN_MAX  = 7'd127;
  localparam logic [7:0] RUN_FLAG = 8'h80;

  // Output word geometry
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CNT_W   = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic in_load;    // capture input item
    logic new_group;  // start or extend the pending group
    logic append;     // move one group byte into the literal buffer
    logic run_emit;   // send a run token word
    logic fl_hdr;     // start a literal token with its header byte
    logic fl_rd;      // read the next literal byte
    logic fl_cap;     // place the read byte into the word buffer
    logic fl_emit;    // send the word buffer
    logic fin;        // mark the stream end on the emitted word
    logic grp_reset;  // return to reset state after a stream
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gc_zero;
    logic gc_one;
    logic gc_three;
    logic gc_ge_min;
    logic gc_max;
    logic b_ne_gv;
    logic lc_zero;
    logic lc_last;
    logic pos_end;
    logic slot_full;
    logic fl_tend;
    logic in_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/rle_literal_run_encoder_unit.sv */
// Channel  Dir  Payload (lowest bit first)                      Marks
// s_*      in   tdata: data_byte[7:0]                           tlast: last_byte
// m_*      out  tdata: token_word[63:0], byte_count[67:64], 0s  tlast: token_end,
//                                                               tuser: stream_end
//
// A byte that emits nothing passes the accept, check, extend, cap test and last test states.
// Closing a group adds a close state and an append state per byte moved into the
// literal buffer; a run token word adds a run state; a final byte adds a close,
// a flush check and a reset state. A literal token takes a header state, then a
// read of the literal RAM and a capture per byte, and an output state per word.
// rst is synchronous, active high; it clears the controller, counters and output.
// The output register takes a new word only when free or being taken; a stalled
// m_tready holds the controller in place, and s_tready is high only when idle.
module rle_literal_run_encoder_unit
  import rle_lit_pkg::*;
#(
  parameter int LITERAL_MAX = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // token_word[63:0], byte_count[67:64], zero[71:68]
  output logic        m_tlast,
  output logic        m_tuser    // stream_end
);

  cmd_t              cmd;
  sts_t              sts;
  logic [WORD_W-1:0] token_word;
  logic [CNT_W-1:0]  byte_count;

  rle_lit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rle_lit_dp #(
    .LITERAL_MAX (LITERAL_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .token_word (token_word),
    .byte_count (byte_count),
    .token_end  (m_tlast),
    .stream_end (m_tuser)
  );

  // Pack output payload
  assign m_tdata = {4'd0, byte_count, token_word};

`ifndef SYNTH
  // Stream end only closes a token
  a_end_in_token: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("stream end outside token end");

  // Word carries one to eight bytes
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
    else $error("byte count out of range");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // An accepted last byte drops s_tready
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("last byte not processed");
`endif

endmodule

/* sv/rle_lit_ram.sv */
module rle_lit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rle_lit_dp.sv */
module rle_lit_dp
  import rle_lit_pkg::*;
#(
  parameter int LITERAL_MAX = 127
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] token_word,
  output logic [CNT_W-1:0]  byte_count,
  output logic              token_end,
  output logic              stream_end
);

  localparam int AW = $clog2(LITERAL_MAX);
  localparam logic [6:0] LIT_LAST = 7'(LITERAL_MAX - 1);

  logic [7:0]        ib;
  logic              il;
  logic [7:0]        gv;
  logic [6:0]        gc;
  logic [6:0]        lc;
  logic [6:0]        pos;
  logic [6:0]        pos_m1;
  logic [CNT_W-1:0]  slot;
  logic [WORD_W-1:0] wbuf;
  logic              tend;
  logic [7:0]        rdata;
  logic [7:0]        run_hdr;

  assign pos_m1  = pos - 7'd1;
  assign run_hdr = RUN_FLAG | {1'b0, gc};

  // Literal buffer
  rle_lit_ram #(
    .WIDTH (8),
    .DEPTH (LITERAL_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (lc[AW-1:0]),
    .wdata (gv),
    .re    (cmd.fl_rd),
    .raddr (pos_m1[AW-1:0]),
    .rdata (rdata)
  );

  // Capture input item
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ib <= data_byte;
      il <= last_byte;
    end
  end

  // Group and literal counters
  always_ff @(posedge clk) begin
    if (rst || cmd.grp_reset) begin
      gv <= 8'd0;
      gc <= 7'd0;
      lc <= 7'd0;
    end else begin
      if (cmd.new_group) begin
        if (gc == 7'd0) begin
          gv <= ib;
        end
        gc <= gc + 7'd1;
      end
      if (cmd.append) begin
        lc <= lc + 7'd1;
        gc <= gc - 7'd1;
      end
      if (cmd.run_emit) begin
        gc <= 7'd0;
      end
      if (cmd.fl_emit && tend) begin
        lc <= 7'd0;
      end
    end
  end

  // Assemble literal token words
  always_ff @(posedge clk) begin
    if (cmd.fl_hdr) begin
      wbuf <= {57'd0, lc};
      slot <= CNT_W'(1);
      pos  <= 7'd1;
    end else if (cmd.fl_cap) begin
      wbuf <= wbuf | ({56'd0, rdata} << {slot[2:0], 3'b000});
      slot <= slot + CNT_W'(1);
      pos  <= pos + 7'd1;
      tend <= (pos == lc);
    end else if (cmd.fl_emit) begin
      wbuf <= '0;
      slot <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.run_emit || cmd.fl_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_emit) begin
      token_word <= {48'd0, gv, run_hdr};
      byte_count <= CNT_W'(2);
      token_end  <= 1'b1;
      stream_end <= cmd.fin;
    end else if (cmd.fl_emit) begin
      token_word <= wbuf;
      byte_count <= slot;
      token_end  <= tend;
      stream_end <= cmd.fin && tend;
    end
  end

  // Status
  always_comb begin
    sts.gc_zero   = (gc == 7'd0);
    sts.gc_one    = (gc == 7'd1);
    sts.gc_three  = (gc == RUN_MIN - 7'd1);
    sts.gc_ge_min = (gc >= RUN_MIN);
    sts.gc_max    = (gc == RUN_MAX);
    sts.b_ne_gv   = (ib != gv);
    sts.lc_zero   = (lc == 7'd0);
    sts.lc_last   = (lc == LIT_LAST);
    sts.pos_end   = (pos == lc);
    sts.slot_full = (slot == CNT_W'(7));
    sts.fl_tend   = tend;
    sts.in_last   = il;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

/* sv/rle_lit_ctrl.sv */
module rle_lit_ctrl
  import rle_lit_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_CLOSE  = 4'd2;
  localparam logic [3:0] S_APPEND = 4'd3;
  localparam logic [3:0] S_NEW    = 4'd4;
  localparam logic [3:0] S_BIG    = 4'd5;
  localparam logic [3:0] S_LAST   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_RST    = 4'd8;
  localparam logic [3:0] S_RUN    = 4'd9;
  localparam logic [3:0] S_FHDR   = 4'd10;
  localparam logic [3:0] S_FRD    = 4'd11;
  localparam logic [3:0] S_FCAP   = 4'd12;
  localparam logic [3:0] S_FOUT   = 4'd13;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic       fin, fin_next;
  logic       cls_last, cls_last_next;
  logic [3:0] after_close;

  assign in_ready    = (state == S_IDLE);
  assign after_close = cls_last ? S_FIN : S_NEW;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      fin      <= 1'b0;
      cls_last <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      fin      <= fin_next;
      cls_last <= cls_last_next;
    end
  end

  // Sequence the per-item steps and token emission
  always_comb begin
    state_next    = state;
    ret_next      = ret;
    fin_next      = fin;
    cls_last_next = cls_last;
    cmd           = '0;
    cmd.fin       = fin;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_CHK;
        end
      end
      S_CHK: begin
        cls_last_next = 1'b0;
        if (!sts.gc_zero && sts.b_ne_gv) begin
          state_next = S_CLOSE;
        end else begin
          state_next = S_NEW;
        end
      end
      // Close the pending group as a run or into the literal buffer
      S_CLOSE: begin
        if (sts.gc_ge_min) begin
          fin_next   = cls_last && sts.lc_zero;
          ret_next   = after_close;
          state_next = S_RUN;
        end else if (sts.gc_zero) begin
          state_next = after_close;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (sts.lc_last) begin
          fin_next   = cls_last && sts.gc_one;
          ret_next   = sts.gc_one ? after_close : S_APPEND;
          state_next = S_FHDR;
        end else if (sts.gc_one) begin
          state_next = after_close;
        end
      end
      // Extend the group; flush literals when it becomes a run
      S_NEW: begin
        cmd.new_group = 1'b1;
        if (sts.gc_three && !sts.lc_zero) begin
          fin_next   = 1'b0;
          ret_next   = S_BIG;
          state_next = S_FHDR;
        end else begin
          state_next = S_BIG;
        end
      end
      S_BIG: begin
        if (sts.gc_max) begin
          fin_next   = sts.in_last && sts.lc_zero;
          ret_next   = S_LAST;
          state_next = S_RUN;
        end else begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (sts.in_last) begin
          cls_last_next = 1'b1;
          state_next    = S_CLOSE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (!sts.lc_zero) begin
          fin_next   = 1'b1;
          ret_next   = S_RST;
          state_next = S_FHDR;
        end else begin
          state_next = S_RST;
        end
      end
      S_RST: begin
        cmd.grp_reset = 1'b1;
        cls_last_next = 1'b0;
        state_next    = S_IDLE;
      end
      S_RUN: begin
        if (sts.out_free) begin
          cmd.run_emit = 1'b1;
          state_next   = ret;
        end
      end
      // Literal token: header, then one buffer byte per read
      S_FHDR: begin
        cmd.fl_hdr = 1'b1;
        state_next = S_FRD;
      end
      S_FRD: begin
        cmd.fl_rd  = 1'b1;
        state_next = S_FCAP;
      end
      S_FCAP: begin
        cmd.fl_cap = 1'b1;
        if (sts.pos_end || sts.slot_full) begin
          state_next = S_FOUT;
        end else begin
          state_next = S_FRD;
        end
      end
      S_FOUT: begin
        if (sts.out_free) begin
          cmd.fl_emit = 1'b1;
          state_next  = sts.fl_tend ? ret : S_FRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
